[hw/rtl/rsts_pkg.sv]
package rsts_pkg;

    // Section catalogue
    localparam int TABLE_SIZE = 42;
    localparam int IDX_W      = 6;
    localparam int AREA_W     = 14;

    typedef logic [AREA_W-1:0] area_t;
    typedef logic [IDX_W-1:0]  idx_t;

    localparam area_t SECTION_TABLE [TABLE_SIZE] = '{
        14'd184,  14'd226,  14'd266,  14'd307,  14'd347,  14'd388,  14'd479,
        14'd527,  14'd575,  14'd625,  14'd684,  14'd744,  14'd806,  14'd866,
        14'd940,  14'd1047, 14'd1138, 14'd1221, 14'd1379, 14'd1539, 14'd1703,
        14'd1903, 14'd2112, 14'd2320, 14'd2512, 14'd2750, 14'd2988, 14'd3276,
        14'd3390, 14'd3477, 14'd3916, 14'd4300, 14'd4565, 14'd4694, 14'd5100,
        14'd5210, 14'd6182, 14'd6190, 14'd6830, 14'd7638, 14'd9060, 14'd9413
    };

    // Fold bounds, hundredths of cm2
    localparam longint AREA_LO     = 184;
    localparam longint AREA_HI     = 9413;
    localparam longint FOLD_SPAN   = AREA_HI - AREA_LO;
    localparam longint FOLD_PERIOD = 2 * FOLD_SPAN;

    // Bias that makes x - AREA_LO non-negative; a whole number of periods
    localparam longint FOLD_BASE_MULT = ((longint'(1) << 31) + AREA_LO) / FOLD_PERIOD + 1;
    localparam longint FOLD_OFFSET    = FOLD_BASE_MULT * FOLD_PERIOD - AREA_LO;

    // Biased value u = hi * 2^U_SPLIT + lo; 2^U_SPLIT folded to its residue
    localparam int     U_W         = 33;
    localparam int     U_SPLIT     = 17;
    localparam longint FOLD_HI_MOD = (longint'(1) << U_SPLIT) % FOLD_PERIOD;

    // Partial residue t = hi * FOLD_HI_MOD + lo, below 2^27
    localparam int     T_W         = 27;

    // Reciprocal quotient estimate, low by at most one
    localparam int     RECIP_SHIFT = 40;
    localparam int     RECIP_W     = 26;
    localparam longint RECIP       = (longint'(1) << RECIP_SHIFT) / FOLD_PERIOD;
    localparam int     Q_W         = 13;
    localparam int     P_W         = 15;
    localparam int     R_W         = 16;

endpackage

[hw/rtl/rsts_fold.sv]
module rsts_fold (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [31:0]           area_in,
    input  logic                  last_in,
    output logic                  fold_valid,
    input  logic                  fold_stall,
    output rsts_pkg::area_t       fold_area,
    output logic                  fold_last
);
    import rsts_pkg::*;

    localparam int NSTG = 5;

    localparam logic [U_W:0]         OFFSET_C = (U_W+1)'(FOLD_OFFSET);
    localparam logic [AREA_W-3:0]    HI_MOD_C = (AREA_W-2)'(FOLD_HI_MOD);
    localparam logic [RECIP_W-1:0]   RECIP_C  = RECIP_W'(RECIP);
    localparam logic [P_W-1:0]       PERIOD_C = P_W'(FOLD_PERIOD);
    localparam logic [R_W-1:0]       PERIOD_R = R_W'(FOLD_PERIOD);
    localparam logic [R_W-1:0]       SPAN_R   = R_W'(FOLD_SPAN);
    localparam logic [R_W-1:0]       LO_R     = R_W'(AREA_LO);

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] adv;
    logic [NSTG-1:0] last_reg;

    logic [U_W-1:0]   u_reg;
    logic [T_W-1:0]   t_reg;
    logic [T_W-1:0]   t3_reg;
    logic [Q_W-1:0]   q_reg;
    logic [R_W-1:0]   r_reg;
    area_t            v_reg;

    logic [U_W:0]              u_next;
    logic [T_W-1:0]            t_next;
    logic [T_W+RECIP_W-1:0]    prod;
    logic [Q_W-1:0]            q_next;
    logic [Q_W+P_W-1:0]        qp;
    logic [R_W-1:0]            r_next;
    logic [R_W-1:0]            d1;
    logic [R_W-1:0]            d2;
    logic [R_W-1:0]            v_wide;

    // stage advance chain: a stage moves when empty or when its successor moves
    always_comb
    begin
        adv[NSTG-1] = !vld_reg[NSTG-1] || !fold_stall;
        for (int k = NSTG-2; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    assign in_stall   = !adv[0];
    assign fold_valid = vld_reg[NSTG-1];
    assign fold_area  = v_reg;
    assign fold_last  = last_reg[NSTG-1];

    always_comb
    begin
        // S1: bias
        u_next = {{2{area_in[31]}}, area_in} + OFFSET_C;
        // S2: fold high part by its residue
        t_next = T_W'(u_reg[U_W-1:U_SPLIT]) * T_W'(HI_MOD_C) + T_W'(u_reg[U_SPLIT-1:0]);
        // S3: quotient estimate
        prod   = t_reg * RECIP_C;
        q_next = prod[RECIP_SHIFT+Q_W-1:RECIP_SHIFT];
        // S4: remainder, below two periods
        qp     = q_reg * PERIOD_C;
        r_next = R_W'(t3_reg - T_W'(qp));
        // S5: correct, reflect, rebase
        d1     = (r_reg >= PERIOD_R) ? (r_reg - PERIOD_R) : r_reg;
        d2     = (d1 > SPAN_R) ? (PERIOD_R - d1) : d1;
        v_wide = d2 + LO_R;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < NSTG; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            u_reg       <= u_next[U_W-1:0];
            last_reg[0] <= last_in;
        end
        if (adv[1])
        begin
            t_reg       <= t_next;
            last_reg[1] <= last_reg[0];
        end
        if (adv[2])
        begin
            t3_reg      <= t_reg;
            q_reg       <= q_next;
            last_reg[2] <= last_reg[1];
        end
        if (adv[3])
        begin
            r_reg       <= r_next;
            last_reg[3] <= last_reg[2];
        end
        if (adv[4])
        begin
            v_reg       <= v_wide[AREA_W-1:0];
            last_reg[4] <= last_reg[3];
        end
    end

    // remainder estimate is never more than one period high
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[3] |-> (r_reg < 2 * PERIOD_R))
        else $error("fold remainder out of bound");

    // folded value stays inside the section range
    a_fold_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[4] |-> (v_reg >= AREA_W'(AREA_LO)) && (v_reg <= AREA_W'(AREA_HI)))
        else $error("folded area out of range");

endmodule

[hw/rtl/rsts_snap.sv]
module rsts_snap (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fold_valid,
    output logic                  fold_stall,
    input  rsts_pkg::area_t       fold_area,
    input  logic                  fold_last,
    output logic                  out_valid,
    input  logic                  out_stall,
    output rsts_pkg::area_t       area_out,
    output rsts_pkg::idx_t        section_index,
    output logic                  last_out
);
    import rsts_pkg::*;

    logic [1:0] vld_reg;
    logic [1:0] adv;
    logic [1:0] last_reg;

    // flag j: value at or past the midpoint between entries j-1 and j
    logic [TABLE_SIZE-1:1] flag_reg;
    logic [TABLE_SIZE-1:1] flag_next;
    logic [TABLE_SIZE:0]   thr;
    logic [TABLE_SIZE-1:0] sel;
    idx_t                  idx_next;
    area_t                 area_next;
    idx_t                  idx_reg;
    area_t                 area_reg;
    logic [AREA_W:0]       twice_v;

    always_comb
    begin
        adv[1] = !vld_reg[1] || !out_stall;
        adv[0] = !vld_reg[0] || adv[1];
    end

    assign fold_stall    = !adv[0];
    assign out_valid     = vld_reg[1];
    assign area_out      = area_reg;
    assign section_index = idx_reg;
    assign last_out      = last_reg[1];

    // 2v >= T[j-1] + T[j] gives the nearer entry, ties to the larger one
    always_comb
    begin
        twice_v = {fold_area, 1'b0};
        for (int j = 1; j < TABLE_SIZE; j++)
        begin
            flag_next[j] = twice_v >= ((AREA_W+1)'(SECTION_TABLE[j-1]) +
                                       (AREA_W+1)'(SECTION_TABLE[j]));
        end
    end

    // thermometer to one-hot, then encode
    always_comb
    begin
        thr       = {1'b0, flag_reg, 1'b1};
        idx_next  = '0;
        area_next = '0;
        for (int j = 0; j < TABLE_SIZE; j++)
        begin
            sel[j] = thr[j] & ~thr[j+1];
            if (sel[j])
            begin
                idx_next  = idx_next | IDX_W'(j);
                area_next = area_next | SECTION_TABLE[j];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= fold_valid;
            end
            if (adv[1])
            begin
                vld_reg[1] <= vld_reg[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            flag_reg    <= flag_next;
            last_reg[0] <= fold_last;
        end
        if (adv[1])
        begin
            idx_reg     <= idx_next;
            area_reg    <= area_next;
            last_reg[1] <= last_reg[0];
        end
    end

    // midpoint flags are monotone, so exactly one entry is picked
    a_one_pick: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[0] |-> $onehot(sel))
        else $error("section select not one-hot");

    // delivered area matches the catalogue entry at the delivered index
    a_area_idx: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[1] |-> (idx_reg < IDX_W'(TABLE_SIZE)) &&
                       (area_reg == SECTION_TABLE[idx_reg]))
        else $error("area and index disagree");

endmodule

[hw/rtl/reflect_and_snap_to_section.sv]
// Reflect-and-snap section quantizer. Each beat on the input carries a signed
// 32-bit candidate area in hundredths of cm2 plus a last flag; each beat on the
// output carries the chosen standard area, its catalogue index and the same
// last flag, exactly one output beat per input beat and in order. The area is
// mirrored into 1.84..94.13 cm2 (a triangle fold of period 18458, done as a
// biased residue: split multiply, reciprocal quotient estimate, one-step
// correction), then snapped to the nearest of the 42 catalogue entries with a
// tie going to the larger entry, by comparing twice the value with the sums of
// neighboring entries in parallel. The pipe is seven register stages deep:
// five in the fold, two in the snap. Throughput is one beat per cycle while
// the output is not stalled, set by the fully pipelined datapath in which
// every stage takes a new beat each cycle. A stall on the output freezes
// only the stages that are full, so bubbles are squeezed out and in_stall
// rises only when all seven stages hold data. There is no configuration and
// no state beyond the pipe.
module reflect_and_snap_to_section (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [31:0]           area_in,
    input  logic                  last_in,
    output logic                  out_valid,
    input  logic                  out_stall,
    output rsts_pkg::area_t       area_out,
    output rsts_pkg::idx_t        section_index,
    output logic                  last_out
);
    import rsts_pkg::*;

    // fold -> snap beat
    logic   fold_valid;
    logic   fold_stall;
    area_t  fold_area;
    logic   fold_last;

    rsts_fold u_fold (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .area_in    (area_in),
        .last_in    (last_in),
        .fold_valid (fold_valid),
        .fold_stall (fold_stall),
        .fold_area  (fold_area),
        .fold_last  (fold_last)
    );

    rsts_snap u_snap (
        .clk           (clk),
        .rst_n         (rst_n),
        .fold_valid    (fold_valid),
        .fold_stall    (fold_stall),
        .fold_area     (fold_area),
        .fold_last     (fold_last),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .area_out      (area_out),
        .section_index (section_index),
        .last_out      (last_out)
    );

endmodule

[dv/tb_reflect_and_snap_to_section.sv]
`timescale 1ns / 100ps

module tb_reflect_and_snap_to_section;

    import rsts_pkg::*;

    // Run limits: worst case per beat is a long sender gap plus a long
    // receiver stall plus the pipe, far below this.
    localparam int  N_RANDOM    = 1400;
    localparam int  N_DIRECTED  = 20;
    localparam int  CYCLE_LIMIT = 1000000;
    localparam int  PIPE_DEPTH  = 7;
    localparam int  HOLD_CYCLES = 300;  // long receiver hold-off
    localparam int  HOLD_AT     = 400;  // beats sent before the hold-off starts
    localparam int  CALM_FROM   = 900;  // window with no idling on either side
    localparam int  CALM_TO     = 1000;

    // One output beat as the block should produce it
    typedef struct packed {
        area_t area;
        idx_t  idx;
        logic  last;
    } section_beat_t;

    // Directed row; when typed is set the expected beat is taken from the row
    typedef struct packed {
        logic [31:0] area;
        logic        last;
        logic        typed;
        area_t       exp_area;
        idx_t        exp_idx;
    } stim_row_t;

    // Hand-picked beats: field extremes, the lowest and highest entries,
    // exact hits, exact ties between neighbors, reflections at both bounds
    // and whole periods away, and some bit patterns.
    localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{32'h8000_0000, 1'b0, 1'b0, 14'd0,    6'd0 },  // most negative
        '{32'h7FFF_FFFF, 1'b1, 1'b0, 14'd0,    6'd0 },  // most positive
        '{32'h0000_0000, 1'b0, 1'b0, 14'd0,    6'd0 },
        '{32'd184,       1'b0, 1'b1, 14'd184,  6'd0 },  // lowest entry itself
        '{32'd9413,      1'b1, 1'b1, 14'd9413, 6'd41},  // top entry and bound
        '{32'd5210,      1'b0, 1'b1, 14'd5210, 6'd35},  // exact hit
        '{32'd205,       1'b0, 1'b1, 14'd226,  6'd1 },  // tie, larger wins
        '{32'd204,       1'b0, 1'b0, 14'd0,    6'd0 },  // one below the tie
        '{32'd6186,      1'b1, 1'b1, 14'd6190, 6'd37},  // tie between close entries
        '{32'd6185,      1'b0, 1'b0, 14'd0,    6'd0 },
        '{32'd183,       1'b0, 1'b0, 14'd0,    6'd0 },  // reflects off low bound
        '{32'd9414,      1'b0, 1'b0, 14'd0,    6'd0 },  // reflects off high bound
        '{-32'sd18274,   1'b0, 1'b1, 14'd184,  6'd0 },  // one period below 184
        '{32'd27871,     1'b1, 1'b1, 14'd9413, 6'd41},  // one period above 9413
        '{32'hFFFF_FFFF, 1'b0, 1'b0, 14'd0,    6'd0 },
        '{32'd9237,      1'b0, 1'b0, 14'd0,    6'd0 },  // just past top midpoint
        '{32'h0000_FFFF, 1'b0, 1'b0, 14'd0,    6'd0 },
        '{32'h5555_5555, 1'b1, 1'b0, 14'd0,    6'd0 },
        '{32'hAAAA_AAAA, 1'b0, 1'b0, 14'd0,    6'd0 },
        '{32'd1703,      1'b1, 1'b1, 14'd1703, 6'd20}
    };

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic [31:0] area_in   = '0;
    logic        last_in   = 1'b0;
    logic        out_stall = 1'b0;
    logic        in_stall;
    logic        out_valid;
    area_t       area_out;
    idx_t        section_index;
    logic        last_out;

    section_beat_t pending_sections [$];
    int            mismatches = 0;
    int            beats_sent = 0;
    bit            sending_done = 1'b0;
    bit            calm = 1'b0;
    int            cycles = 0;

    reflect_and_snap_to_section dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .area_in       (area_in),
        .last_in       (last_in),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .area_out      (area_out),
        .section_index (section_index),
        .last_out      (last_out)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Mirror the area into AREA_LO..AREA_HI, then pick the nearest catalogue
    // entry; an exact tie goes to the upper neighbor.
    function automatic section_beat_t snap_section(logic [31:0] raw, logic last);
        section_beat_t beat;
        longint        d;
        longint        v;
        int            pick;
        bit            found;
        d     = (longint'($signed(raw)) - AREA_LO) % FOLD_PERIOD;
        pick  = TABLE_SIZE - 1;
        found = 1'b0;
        if (d < 0)
            d += FOLD_PERIOD;
        if (d > FOLD_SPAN)
            d = FOLD_PERIOD - d;
        v = AREA_LO + d;
        for (int j = 0; j < TABLE_SIZE; j++)
        begin
            if (!found && v <= longint'(SECTION_TABLE[j]))
            begin
                found = 1'b1;
                if (j == 0)
                    pick = 0;
                else if (longint'(SECTION_TABLE[j]) - v <= v - longint'(SECTION_TABLE[j-1]))
                    pick = j;
                else
                    pick = j - 1;
            end
        end
        beat.area = SECTION_TABLE[pick];
        beat.idx  = idx_t'(pick);
        beat.last = last;
        return beat;
    endfunction

    // Mostly zero, sometimes a few cycles, rarely a long pause
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Random area: in-range values, values near entries and midpoints,
    // in-range values moved whole periods away (plain or mirrored), and
    // raw random 32-bit noise.
    function automatic logic [31:0] pick_area();
        int     r;
        int     j;
        longint v;
        longint k;
        r = $urandom_range(0, 99);
        if (r < 35)
            return 32'($urandom_range(AREA_LO, AREA_HI));
        if (r < 45)
        begin
            j = $urandom_range(0, TABLE_SIZE - 1);
            return 32'(int'(SECTION_TABLE[j]) + $urandom_range(0, 4) - 2);
        end
        if (r < 55)
        begin
            j = $urandom_range(0, TABLE_SIZE - 2);
            v = (longint'(SECTION_TABLE[j]) + longint'(SECTION_TABLE[j+1])) / 2;
            return 32'(v + $urandom_range(0, 2) - 1);
        end
        if (r < 70)
        begin
            v = $urandom_range(AREA_LO, AREA_HI);
            if ($urandom_range(0, 1))
                v = 2 * AREA_LO - v;
            k = longint'($urandom_range(0, 232000)) - 116000;
            return 32'(v + k * FOLD_PERIOD);
        end
        return $urandom();
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Offer one beat, hold it until taken, then queue what should come back
    task automatic send_beat(logic [31:0] area, logic last, section_beat_t want);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        area_in  <= area;
        last_in  <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_sections.push_back(want);
        beats_sent++;
        calm = (beats_sent >= CALM_FROM && beats_sent < CALM_TO);
    endtask

    // Sender: reset, the directed table, then the random beats
    initial
    begin
        logic [31:0]   a;
        logic          l;
        section_beat_t want;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (DIRECTED_ROWS[i])
        begin
            if (DIRECTED_ROWS[i].typed)
                want = '{DIRECTED_ROWS[i].exp_area, DIRECTED_ROWS[i].exp_idx,
                         DIRECTED_ROWS[i].last};
            else
                want = snap_section(DIRECTED_ROWS[i].area, DIRECTED_ROWS[i].last);
            send_beat(DIRECTED_ROWS[i].area, DIRECTED_ROWS[i].last, want);
        end
        for (int n = 0; n < N_RANDOM; n++)
        begin
            a = pick_area();
            l = ($urandom_range(0, 7) == 0);
            send_beat(a, l, snap_section(a, l));
        end
        in_valid <= 1'b0;
        sending_done = 1'b1;
    end

    // Receiver: random stalls, one long hold-off so the pipe fills and the
    // input backs up, and a calm window with no stalls at all
    initial
    begin
        int  n;
        bit  held;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held && beats_sent >= HOLD_AT)
            begin
                out_stall <= 1'b1;
                for (int c = 0; c < HOLD_CYCLES; c++)
                    @(posedge clk);
                held = 1'b1;
            end
            else if (calm)
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                n = pick_gap();
                if (n > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                end
                out_stall <= 1'b0;
                repeat (1 + pick_gap()) @(posedge clk);
            end
        end
    end

    // Output checker: every taken beat against the oldest pending one
    always @(posedge clk)
    begin
        section_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_sections.size() == 0)
            begin
                report_mismatch("beats pending", 0, 1);
            end
            else
            begin
                want = pending_sections.pop_front();
                if (area_out !== want.area)
                    report_mismatch("area_out", area_out, want.area);
                if (section_index !== want.idx)
                    report_mismatch("section_index", section_index, want.idx);
                if (last_out !== want.last)
                    report_mismatch("last_out", last_out, want.last);
            end
        end
    end

    // Watchdog
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("[%0t] timeout with %0d beats pending", $time, pending_sections.size());
        $display("FAIL");
        $finish;
    end

    // End of run: drain, let the pipe settle, then the verdict
    initial
    begin
        wait (sending_done);
        while (pending_sections.size() != 0)
            @(posedge clk);
        repeat (2 * PIPE_DEPTH) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
